### src/linear_probe_symbol_table_core_macros.svh
// Assertion macros for the symbol table RTL.
`ifndef LINEAR_PROBE_SYMBOL_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_SYMBOL_TABLE_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define LPST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpst assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LPST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpst assertion failed");

`endif

### src/lpst_pkg.sv
package lpst_pkg;

   // Default sizing.
   localparam int SLOTS_DEF      = 256;
   localparam int NAME_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH    = 2;

   // Field widths fixed by the item format.
   localparam int CMD_W    = 2;
   localparam int NAME_W   = 64;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = 9;
   localparam int REQ_W    = 112;
   localparam int RSP_W    = 112;
   localparam int ENTRY_W  = NAME_W + VALUE_W + 1;

   localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 9'd256;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INS_VAL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INS_TYP = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   // One result item.
   typedef struct packed {
      logic [NAME_W-1:0]   name_out;
      logic                entry_kind;
      logic [VALUE_W-1:0]  value_out;
      logic [INDEX_W-1:0]  slot;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

### src/lpst_ram.sv
module lpst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lpst_fifo.sv
module lpst_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/lpst_front.sv
module lpst_front #(
   parameter int SLOTS      = lpst_pkg::SLOTS_DEF,
   parameter int NAME_BYTES = lpst_pkg::NAME_BYTES_DEF,
   parameter int NW         = $clog2(SLOTS + 1),
   parameter int SW         = $clog2(SLOTS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [NW-1:0]                     size_eff,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [lpst_pkg::CMD_W-1:0]        in_cmd,
   input  logic [lpst_pkg::NAME_W-1:0]       in_name,
   input  logic [lpst_pkg::VALUE_W-1:0]      in_value,
   input  logic [lpst_pkg::INDEX_W-1:0]      in_index,
   output logic                              q_push,
   output logic [SW+lpst_pkg::CMD_W+lpst_pkg::NAME_W+lpst_pkg::VALUE_W+lpst_pkg::INDEX_W-1:0]
                                             q_data,
   input  logic                              q_full
);
   import lpst_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [NAME_W-1:0]  name_ff, name_canon;
   logic [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [31:0]        dvd_ff, dvd_in;
   logic [NW-1:0]      rem_ff, rem_in;
   logic [NW:0]        rem_shift;
   logic [4:0]         bit_ff, bit_in;
   logic               accept;

   // A name ends at its first zero byte or at the byte limit.
   always_comb begin
      logic live;
      live       = 1'b1;
      name_canon = '0;
      for (int i = 0; i < 8; i++) begin
         if (i >= NAME_BYTES || in_name[8*i +: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            name_canon[8*i +: 8] = in_name[8*i +: 8];
         end
      end
   end

   assign in_ready = (state_ff == F_IDLE);
   assign accept   = in_valid && in_ready;

   // Hash reduction: restoring remainder, one dividend bit a cycle.
   assign rem_shift = {rem_ff, dvd_ff[31]};

   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               dvd_in   = name_canon[31:0] ^ name_canon[63:32];
               rem_in   = '0;
               bit_in   = 5'd31;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            dvd_in = {dvd_ff[30:0], 1'b0};
            if (rem_shift >= {1'b0, size_eff}) begin
               rem_in = NW'(rem_shift - {1'b0, size_eff});
            end else begin
               rem_in = NW'(rem_shift);
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd0) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Item payload and divider datapath.
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      if (accept) begin
         cmd_ff   <= in_cmd;
         name_ff  <= name_canon;
         value_ff <= in_value;
         index_ff <= in_index;
      end
   end

   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_data = {SW'(rem_ff), index_ff, value_ff, name_ff, cmd_ff};

endmodule

### src/lpst_back.sv
module lpst_back #(
   parameter int SLOTS = lpst_pkg::SLOTS_DEF,
   parameter int NW    = $clog2(SLOTS + 1),
   parameter int SW    = $clog2(SLOTS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [NW-1:0]                     size_eff,
   output logic                              q_pop,
   input  logic [SW+lpst_pkg::CMD_W+lpst_pkg::NAME_W+lpst_pkg::VALUE_W+lpst_pkg::INDEX_W-1:0]
                                             q_data,
   input  logic                              q_empty,
   output logic                              out_valid,
   input  logic                              out_ready,
   output lpst_pkg::rsp_type                 out_item
);
   import lpst_pkg::*;
   `include "linear_probe_symbol_table_core_macros.svh"

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_PROBE  = 3'd1;
   localparam logic [2:0] B_CHECK  = 3'd2;
   localparam logic [2:0] B_FINISH = 3'd3;
   localparam logic [2:0] B_RADDR  = 3'd4;
   localparam logic [2:0] B_RCHECK = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [NAME_W-1:0]  name_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [SW-1:0]      ptr_ff, ptr_in, match_ff, match_in, hole_ff, hole_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic               found_ff, found_in, have_hole_ff, have_hole_in;
   logic [ENTRY_W-1:0] hit_ff, hit_in;
   logic [SLOTS-1:0]   used_ff;
   logic               set_used;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               ram_we;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic               pop;
   logic [SW-1:0]      next_ptr;
   logic               is_used;
   logic               rd_hit;

   // Slot contents: name, value and kind in one word.
   lpst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hole_ff),
      .wr_data (ram_wdata),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   // The result register is free whenever a new item is taken.
   assign pop      = (state_ff == B_IDLE) && !q_empty && !out_valid_ff;
   assign q_pop    = pop;
   assign is_used  = used_ff[ptr_ff];
   assign next_ptr = (32'(ptr_ff) + 32'd1 == 32'(size_eff)) ? '0 : ptr_ff + 1'b1;
   assign rd_hit   = (32'(index_ff) < 32'(size_eff)) && is_used;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      match_in     = match_ff;
      have_hole_in = have_hole_ff;
      hole_in      = hole_ff;
      hit_in       = hit_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      ram_we       = 1'b0;
      ram_wdata    = '0;
      set_used     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               cnt_in       = '0;
               found_in     = 1'b0;
               have_hole_in = 1'b0;
               if (q_data[CMD_W-1:0] == CMD_READ) begin
                  ptr_in   = SW'(32'(q_data[CMD_W+NAME_W+VALUE_W +: INDEX_W]));
                  state_in = B_RADDR;
               end else begin
                  ptr_in   = q_data[CMD_W+NAME_W+VALUE_W+INDEX_W +: SW];
                  state_in = B_PROBE;
               end
            end
         end
         B_PROBE: state_in = B_CHECK;
         B_CHECK: begin
            // Probe one slot: first matching name, first free slot.
            if (is_used) begin
               if (!found_ff && ram_rdata[NAME_W-1:0] == name_ff) begin
                  found_in = 1'b1;
                  match_in = ptr_ff;
                  hit_in   = ram_rdata;
               end
            end else if (!have_hole_ff) begin
               have_hole_in = 1'b1;
               hole_in      = ptr_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            ptr_in = next_ptr;
            if (cnt_in == size_eff || found_in) begin
               state_in = B_FINISH;
            end else begin
               state_in = B_PROBE;
            end
         end
         B_FINISH: begin
            out_valid_in = 1'b1;
            state_in     = B_IDLE;
            out_in       = '0;
            if (found_ff) begin
               out_in.status     = ST_FOUND;
               out_in.slot       = INDEX_W'(32'(match_ff));
               out_in.name_out   = hit_ff[NAME_W-1:0];
               out_in.value_out  = hit_ff[NAME_W +: VALUE_W];
               out_in.entry_kind = hit_ff[ENTRY_W-1];
            end else if (cmd_ff == CMD_LOOKUP) begin
               out_in.status = ST_NOT_FOUND;
            end else if (!have_hole_ff) begin
               out_in.status = ST_FULL;
            end else begin
               // Place a new entry in the first free slot seen.
               ram_we            = 1'b1;
               set_used          = 1'b1;
               out_in.status     = ST_INSERTED;
               out_in.slot       = INDEX_W'(32'(hole_ff));
               out_in.name_out   = name_ff;
               out_in.entry_kind = (cmd_ff != CMD_INS_VAL);
               out_in.value_out  = (cmd_ff == CMD_INS_VAL) ? value_ff : '0;
               ram_wdata = {out_in.entry_kind, out_in.value_out, name_ff};
            end
         end
         B_RADDR: state_in = B_RCHECK;
         B_RCHECK: begin
            out_valid_in = 1'b1;
            state_in     = B_IDLE;
            out_in       = '0;
            out_in.slot  = index_ff;
            if (rd_hit) begin
               out_in.status     = ST_FOUND;
               out_in.name_out   = ram_rdata[NAME_W-1:0];
               out_in.value_out  = ram_rdata[NAME_W +: VALUE_W];
               out_in.entry_kind = ram_rdata[ENTRY_W-1];
            end else begin
               out_in.status = ST_EMPTY;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (set_used) begin
            used_ff[hole_ff] <= 1'b1;
         end
      end
   end

   // Probe datapath and result payload.
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      match_ff     <= match_in;
      have_hole_ff <= have_hole_in;
      hole_ff      <= hole_in;
      hit_ff       <= hit_in;
      out_ff       <= out_in;
      if (pop) begin
         cmd_ff   <= q_data[CMD_W-1:0];
         name_ff  <= q_data[CMD_W +: NAME_W];
         value_ff <= q_data[CMD_W+NAME_W +: VALUE_W];
         index_ff <= q_data[CMD_W+NAME_W+VALUE_W +: INDEX_W];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   `LPST_ASSERT_IMP(a_probe_in_range, clock, reset,
      state_ff == B_CHECK, 32'(ptr_ff) < 32'(size_eff))
   `LPST_ASSERT_IMP(a_status_legal, clock, reset,
      out_valid_ff, out_ff.status <= ST_EMPTY)
   `LPST_ASSERT_NEXT(a_insert_marks_used, clock, reset,
      set_used, used_ff[$past(hole_ff)])
   `LPST_ASSERT_IMP(a_no_pop_while_busy, clock, reset,
      pop, !out_valid_ff && state_ff == B_IDLE)

endmodule

### src/linear_probe_symbol_table_core.sv
// A request passes the front (32-step hash remainder), the queue and the back, which probes
// slots one at a time (at most table_size of them); a slot read reads its one slot directly.
// The front takes no new item until its current one is pushed into the queue; the back
// takes one only when idle and waits until the previous result is taken.
// A two-entry queue lets the front take a new item while the back probes.
// Reset clears every occupied bit at once and sets table_size to 256.
module linear_probe_symbol_table_core #(
   parameter int SLOTS      = lpst_pkg::SLOTS_DEF,
   parameter int NAME_BYTES = lpst_pkg::NAME_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lpst_pkg::SIZE_W-1:0] csr_data,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // command[1:0], name_key[65:2], value_in[97:66], slot_index[105:98], zeros
   input  logic [lpst_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[2:0], slot[10:3], value_out[42:11], entry_kind[43],
   // name_out[107:44], zeros
   output logic [lpst_pkg::RSP_W-1:0]  rsp_tdata
);
   import lpst_pkg::*;

   localparam int NW = $clog2(SLOTS + 1);
   localparam int SW = $clog2(SLOTS);
   localparam int QW = SW + CMD_W + NAME_W + VALUE_W + INDEX_W;

   logic [SIZE_W-1:0] size_ff;
   logic [NW-1:0]     size_eff;
   logic              q_push, q_full, q_pop, q_empty;
   logic [QW-1:0]     q_in, q_out;
   rsp_type           rsp_item;

   // Table size register; zero acts as one, large values clamp to SLOTS.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= TABLE_SIZE_RST;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         size_eff = NW'(1);
      end else if (32'(size_ff) > SLOTS) begin
         size_eff = NW'(SLOTS);
      end else begin
         size_eff = NW'(32'(size_ff));
      end
   end

   lpst_front #(
      .SLOTS      (SLOTS),
      .NAME_BYTES (NAME_BYTES),
      .NW         (NW),
      .SW         (SW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .size_eff (size_eff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (req_tdata[1:0]),
      .in_name  (req_tdata[65:2]),
      .in_value (req_tdata[97:66]),
      .in_index (req_tdata[105:98]),
      .q_push   (q_push),
      .q_data   (q_in),
      .q_full   (q_full)
   );

   lpst_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   lpst_back #(
      .SLOTS (SLOTS),
      .NW    (NW),
      .SW    (SW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .size_eff  (size_eff),
      .q_pop     (q_pop),
      .q_data    (q_out),
      .q_empty   (q_empty),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {4'b0, rsp_item};

endmodule

### bench/linear_probe_symbol_table_core_checker.sv
// Watches the request, response and register channels, keeps its own copy of the
// symbol table, and compares every response with the oldest prediction.
module linear_probe_symbol_table_core_checker
   import lpst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   output int                error_count,
   output int                pending_count,
   output int                inserted_count,
   output int                full_count
);

   // Shadow copy of the table.
   logic [SIZE_W-1:0]  size_reg;
   logic               shadow_used [256];
   logic [NAME_W-1:0]  shadow_name [256];
   logic [VALUE_W-1:0] shadow_value [256];
   logic               shadow_kind [256];
   rsp_type            expected_rsps [$];

   // Strip bytes after the first zero byte.
   function automatic logic [NAME_W-1:0] trimmed_name(input logic [NAME_W-1:0] key);
      logic [NAME_W-1:0] result;
      result = '0;
      for (int b = 0; b < 8; b++) begin
         if (key[8*b +: 8] == 8'd0) break;
         result[8*b +: 8] = key[8*b +: 8];
      end
      return result;
   endfunction

   // Serve one command against the shadow table and return the expected response.
   function automatic rsp_type serve_command(input logic [REQ_W-1:0] item);
      logic [CMD_W-1:0]   cmd;
      logic [NAME_W-1:0]  key;
      logic [VALUE_W-1:0] val;
      logic [INDEX_W-1:0] idx;
      int unsigned n, pos, hit_slot, free_slot;
      bit hit, have_free;
      rsp_type r;
      cmd = item[1:0];
      key = trimmed_name(item[65:2]);
      val = item[97:66];
      idx = item[105:98];
      n = (size_reg == 0) ? 1 : (size_reg > 256) ? 256 : size_reg;
      r = '0;
      hit = 0;
      have_free = 0;
      hit_slot = 0;
      free_slot = 0;
      if (cmd == CMD_READ) begin
         r.slot = idx;
         if (idx < n && shadow_used[idx]) begin
            r.status = ST_FOUND;
            r.value_out = shadow_value[idx];
            r.entry_kind = shadow_kind[idx];
            r.name_out = shadow_name[idx];
         end else begin
            r.status = ST_EMPTY;
         end
         return r;
      end
      pos = (key[31:0] ^ key[63:32]) % n;
      for (int unsigned i = 0; i < n; i++) begin
         if (shadow_used[pos]) begin
            if (!hit && shadow_name[pos] == key) begin
               hit = 1;
               hit_slot = pos;
            end
         end else if (!have_free) begin
            have_free = 1;
            free_slot = pos;
         end
         pos = (pos + 1 == n) ? 0 : pos + 1;
      end
      if (hit) begin
         r.status = ST_FOUND;
         r.slot = INDEX_W'(hit_slot);
         r.value_out = shadow_value[hit_slot];
         r.entry_kind = shadow_kind[hit_slot];
         r.name_out = shadow_name[hit_slot];
      end else if (cmd == CMD_LOOKUP) begin
         r.status = ST_NOT_FOUND;
      end else if (!have_free) begin
         r.status = ST_FULL;
      end else begin
         shadow_used[free_slot] = 1;
         shadow_name[free_slot] = key;
         shadow_value[free_slot] = (cmd == CMD_INS_VAL) ? val : '0;
         shadow_kind[free_slot] = (cmd == CMD_INS_TYP);
         r.status = ST_INSERTED;
         r.slot = INDEX_W'(free_slot);
         r.value_out = shadow_value[free_slot];
         r.entry_kind = shadow_kind[free_slot];
         r.name_out = key;
      end
      return r;
   endfunction

   // Track every handshake at the rising edge.
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         size_reg <= TABLE_SIZE_RST;
         for (int i = 0; i < 256; i++) shadow_used[i] = 0;
         expected_rsps.delete();
         error_count <= 0;
         inserted_count <= 0;
         full_count <= 0;
      end else begin
         if (csr_valid && csr_ready) size_reg <= csr_data;
         if (req_tvalid && req_tready) begin
            want = serve_command(req_tdata);
            expected_rsps.push_back(want);
            if (want.status == ST_INSERTED) inserted_count <= inserted_count + 1;
            if (want.status == ST_FULL) full_count <= full_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[STATUS_W+INDEX_W+VALUE_W+1+NAME_W-1:0];
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.value_out !== want.value_out ||
                   got.entry_kind !== want.entry_kind ||
                   got.name_out !== want.name_out || rsp_tdata[RSP_W-1:108] !== '0) begin
                  $display("%0t: response mismatch, expected %h, actual %h",
                           $time, want, got);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count = expected_rsps.size();
   end

endmodule

### bench/linear_probe_symbol_table_core_tb.sv
module linear_probe_symbol_table_core_tb;
   import lpst_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   int                error_count, pending_count, inserted_count, full_count;
   int                rsp_seen;
   bit                long_hold;
   logic [NAME_W-1:0] name_pool [32];

   linear_probe_symbol_table_core DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   linear_probe_symbol_table_core_checker checker_inst (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count),
      .inserted_count(inserted_count), .full_count(full_count)
   );

   // Clock generation.
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Time limit for a hung block.
   initial begin
      #20000000;
      $display("linear_probe_symbol_table_core_tb: done, errors");
      $finish;
   end

   // Response side: random stalls per item, plus one long hold-off on request.
   initial begin
      int wait_cycles;
      rsp_tready = 0;
      rsp_seen = 0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (1500) @(posedge clock);
            long_hold = 0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (wait_cycles != 0) begin
            rsp_tready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock iff rsp_tvalid);
         rsp_seen++;
      end
   end

   // Write the table size while nothing is in flight.
   task automatic write_size(input logic [SIZE_W-1:0] size_val);
      wait_drained();
      csr_valid <= 1;
      csr_data <= size_val;
      @(posedge clock iff csr_ready);
      csr_valid <= 0;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock iff pending_count == 0);
      repeat (2 * 256 + 60) @(posedge clock);
   endtask

   // Offer one request and hold it until it is taken; the next call with a gap or a drain
   // drops the valid.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NAME_W-1:0] key,
                            input logic [VALUE_W-1:0] val, input logic [INDEX_W-1:0] idx,
                            input bit no_gap);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, idx, val, key, cmd};
      @(posedge clock iff req_tready);
   endtask

   // Names of random length, sometimes with bytes after an embedded zero.
   function automatic logic [NAME_W-1:0] random_name();
      logic [NAME_W-1:0] key;
      int len;
      key = {$urandom, $urandom};
      len = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0)
         for (int b = len; b < 8; b++) key[8*b +: 8] = 8'd0;
      else if (len < 8)
         key[8*len +: 8] = 8'd0;
      return key;
   endfunction

   task automatic random_phase(input int count, input int pool_size);
      logic [CMD_W-1:0] cmd;
      logic [NAME_W-1:0] key;
      for (int i = 0; i < count; i++) begin
         cmd = CMD_W'($urandom_range(0, 3));
         key = ($urandom_range(0, 4) != 0) ? name_pool[$urandom_range(0, pool_size - 1)]
                                           : random_name();
         send_item(cmd, key, $urandom, INDEX_W'($urandom), 0);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int sizes [6];
      sizes = '{1, 0, 300, 7, 256, 3};
      reset = 1;
      csr_valid = 0;
      csr_data = '0;
      req_tvalid = 0;
      req_tdata = '0;
      long_hold = 0;
      for (int i = 0; i < 32; i++) name_pool[i] = random_name();
      repeat (4) @(posedge clock);
      reset <= 0;

      // Directed items at the default size.
      send_item(CMD_LOOKUP, 64'h0, 0, 0, 0);
      send_item(CMD_INS_VAL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000, 0, 0);
      send_item(CMD_INS_VAL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_item(CMD_INS_TYP, 64'h0000_0000_0000_0041, 0, 0, 0);
      send_item(CMD_INS_TYP, 64'h0000_0000_0000_0041, 0, 0, 0);
      send_item(CMD_INS_VAL, 64'h0000_0000_0000_0041, 32'hFFFF_FFFF, 0, 0);
      send_item(CMD_INS_VAL, 64'hAB00_CDEF_0012_0041, 5, 0, 0);
      send_item(CMD_INS_VAL, 64'h0000_0001_0000_0000, 9, 0, 0);
      send_item(CMD_INS_VAL, 64'h0000_0000_0000_0001, 10, 0, 0);
      send_item(CMD_LOOKUP, 64'h0000_0000_0000_0001, 0, 0, 0);
      send_item(CMD_LOOKUP, 64'h8080_8080_8080_8080, 0, 0, 0);
      for (int i = 0; i < 256; i += 85) send_item(CMD_READ, 0, 0, INDEX_W'(i), 0);
      send_item(CMD_READ, 0, 0, 8'hFF, 0);

      // Long response hold-off while requests keep coming.
      long_hold = 1;
      for (int i = 0; i < 12; i++) send_item(CMD_LOOKUP, name_pool[i], 0, 0, 1);

      // Several sizes, including the wrap and full cases.
      foreach (sizes[k]) begin
         write_size(SIZE_W'(sizes[k]));
         random_phase((sizes[k] <= 7 && sizes[k] != 0) ? 40 : 150,
                      (sizes[k] <= 7) ? 12 : 32);
      end
      write_size(9'd2);
      random_phase(60, 6);
      write_size(9'd511);
      random_phase(540, 32);

      // Drain and verdict.
      req_tvalid <= 0;
      @(posedge clock iff pending_count == 0);
      repeat (600) @(posedge clock);
      $display("Covered %0d responses: %0d inserts, %0d full-table results, sizes 0..511.",
               rsp_seen, inserted_count, full_count);
      if (error_count == 0)
         $display("linear_probe_symbol_table_core_tb: done, clean");
      else
         $display("linear_probe_symbol_table_core_tb: done, errors");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/lpst_pkg.sv
src/lpst_ram.sv
src/lpst_fifo.sv
src/lpst_front.sv
src/lpst_back.sv
src/linear_probe_symbol_table_core.sv
bench/linear_probe_symbol_table_core_checker.sv
bench/linear_probe_symbol_table_core_tb.sv
